@@ src/idt_pkg.sv @@
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types, constants and helpers for the id translation table.
// ----------------------------------------------------------------------------
package idt_pkg;

   // id and field widths
   localparam int ID_W       = 31;
   localparam int CMD_W      = 3;
   localparam int ECNT_W     = 7;
   localparam int SLOTS_DEF  = 64;

   // configuration port
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam logic [CSR_AW-3:0] REG_MAPPING_ACTIVE = '0;

   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_REGISTER = 3'd1,
      CMD_ALLOC    = 3'd2,
      CMD_HOST_OF  = 3'd3,
      CMD_GUEST_OF = 3'd4,
      CMD_REMOVE   = 3'd5
   } cmd_type;

   // search packet handed from cell to cell
   typedef struct packed {
      logic            vld;
      logic            hit;
      logic [ID_W-1:0] hit_val;
      logic            free_hit;
   } scan_type;

   // slot write broadcast to all cells
   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] guest;
      logic [ID_W-1:0] host;
   } wr_type;

   // raise the guest counter past a guest that was just added
   function automatic logic [ID_W-1:0] raise_next(input logic [ID_W-1:0] nxt,
                                                  input logic [ID_W-1:0] guest);
      logic [ID_W-1:0] r;
      r = nxt;
      if (nxt <= guest) begin
         r = (guest == ID_MAX) ? ID_MAX : guest + 1'b1;
      end
      return r;
   endfunction

   // saturating increment of the guest counter
   function automatic logic [ID_W-1:0] bump_next(input logic [ID_W-1:0] nxt);
      return (nxt == ID_MAX) ? ID_MAX : nxt + 1'b1;
   endfunction

endpackage

@@ src/id_translation_table.sv @@
// ----------------------------------------------------------------------------
// id_translation_table
// Guest/host id pairing table built as a chain of slot cells.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    cmd, guest_id, host_id
//   rsp      out        rsp_valid/ready    status, result_id, entry_count
//   csr      in         psel/penable       mapping_active at address 0
//
// From acceptance to the next acceptance each transfer passes a launch
// cycle, the walk of the search packet down the cell chain (one cell per
// cycle), an execute cycle that applies the command and may write a slot,
// and an idle cycle in which the next request is taken.
// Reset clears every slot, the guest counter (to 1) and the count at once.
// A response waiting in the output register does not block the next
// request; only the execute cycle waits for the output register to free up.
// ----------------------------------------------------------------------------
module id_translation_table #(
   parameter int SLOTS = idt_pkg::SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [idt_pkg::CMD_W-1:0]    req_cmd,
   input  logic [idt_pkg::ID_W-1:0]     req_guest_id,
   input  logic [idt_pkg::ID_W-1:0]     req_host_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic [idt_pkg::ID_W-1:0]     rsp_result_id,
   output logic [idt_pkg::ECNT_W-1:0]   rsp_entry_count,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [idt_pkg::CSR_AW-1:0]   paddr,
   input  logic [idt_pkg::CSR_DW-1:0]   pwdata,
   output logic [idt_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import idt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic             mapping_active_ff;
   logic             csr_hit;
   logic [ID_W-1:0]  key;
   logic             by_host, launch;
   wr_type           wr;
   logic [IDX_W-1:0] wr_idx;
   scan_type         scan [SLOTS+1];
   logic [IDX_W-1:0] hit_idx [SLOTS+1];
   logic [IDX_W-1:0] free_idx [SLOTS+1];

   // configuration register
   assign csr_hit = (paddr[CSR_AW-1:2] == REG_MAPPING_ACTIVE);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? {{(CSR_DW-1){1'b0}}, mapping_active_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mapping_active_ff <= 1'b0;
      end else if (psel && penable && pwrite && csr_hit) begin
         mapping_active_ff <= pwdata[0];
      end
   end

   // packet entering the first cell
   assign scan[0]     = '{vld: launch, hit: 1'b0, hit_val: '0, free_hit: 1'b0};
   assign hit_idx[0]  = '0;
   assign free_idx[0] = '0;

   // cell chain
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      idt_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (key),
         .by_host      (by_host),
         .scan_in      (scan[i]),
         .hit_idx_in   (hit_idx[i]),
         .free_idx_in  (free_idx[i]),
         .scan_out     (scan[i+1]),
         .hit_idx_out  (hit_idx[i+1]),
         .free_idx_out (free_idx[i+1]),
         .wr           (wr),
         .wr_idx       (wr_idx)
      );
   end

   idt_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_guest_id    (req_guest_id),
      .req_host_id     (req_host_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_entry_count (rsp_entry_count),
      .mapping_active  (mapping_active_ff),
      .key             (key),
      .by_host         (by_host),
      .launch          (launch),
      .scan_last       (scan[SLOTS]),
      .hit_idx_last    (hit_idx[SLOTS]),
      .free_idx_last   (free_idx[SLOTS]),
      .wr              (wr),
      .wr_idx          (wr_idx)
   );

endmodule

@@ src/idt_cell.sv @@
// ----------------------------------------------------------------------------
// idt_cell
// One table slot: holds a guest/host pair, checks the search packet that
// passes through and hands it on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module idt_cell #(
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [idt_pkg::ID_W-1:0]  key,
   input  logic                      by_host,
   input  idt_pkg::scan_type         scan_in,
   input  logic [IDX_W-1:0]          hit_idx_in,
   input  logic [IDX_W-1:0]          free_idx_in,
   output idt_pkg::scan_type         scan_out,
   output logic [IDX_W-1:0]          hit_idx_out,
   output logic [IDX_W-1:0]          free_idx_out,
   input  idt_pkg::wr_type           wr,
   input  logic [IDX_W-1:0]          wr_idx
);
   import idt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [ID_W-1:0] guest_ff, host_ff;
   scan_type        scan_ff, scan_in_c;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in_c;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in_c;
   logic            occ, match;

   assign occ   = (guest_ff != '0);
   assign match = occ && (by_host ? (host_ff == key) : (guest_ff == key));

   // first match and first empty slot win
   always_comb begin
      scan_in_c     = scan_in;
      hit_idx_in_c  = hit_idx_in;
      free_idx_in_c = free_idx_in;
      if (!scan_in.hit && match) begin
         scan_in_c.hit     = 1'b1;
         scan_in_c.hit_val = by_host ? guest_ff : host_ff;
         hit_idx_in_c      = MY_IDX;
      end
      if (!scan_in.free_hit && !occ) begin
         scan_in_c.free_hit = 1'b1;
         free_idx_in_c      = MY_IDX;
      end
   end

   // packet stage and slot contents
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         guest_ff <= '0;
         host_ff  <= '0;
      end else begin
         scan_ff <= scan_in_c;
         if (wr.en && (wr_idx == MY_IDX)) begin
            guest_ff <= wr.guest;
            host_ff  <= wr.host;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in_c;
      free_idx_ff <= free_idx_in_c;
   end

   assign scan_out     = scan_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

@@ src/idt_ctrl.sv @@
// ----------------------------------------------------------------------------
// idt_ctrl
// Command sequencer: takes a request, launches a search down the cell chain,
// applies the command once the packet leaves the last cell, and holds the
// response register.
// ----------------------------------------------------------------------------
module idt_ctrl #(
   parameter int SLOTS = idt_pkg::SLOTS_DEF,
   parameter int IDX_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [idt_pkg::CMD_W-1:0]  req_cmd,
   input  logic [idt_pkg::ID_W-1:0]   req_guest_id,
   input  logic [idt_pkg::ID_W-1:0]   req_host_id,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_status,
   output logic [idt_pkg::ID_W-1:0]   rsp_result_id,
   output logic [idt_pkg::ECNT_W-1:0] rsp_entry_count,
   input  logic                       mapping_active,
   output logic [idt_pkg::ID_W-1:0]   key,
   output logic                       by_host,
   output logic                       launch,
   input  idt_pkg::scan_type          scan_last,
   input  logic [IDX_W-1:0]           hit_idx_last,
   input  logic [IDX_W-1:0]           free_idx_last,
   output idt_pkg::wr_type            wr,
   output logic [IDX_W-1:0]           wr_idx
);
   import idt_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [ID_W-1:0]  guest_ff, host_ff;
   logic             launch_ff;
   logic             hit_ff, free_ff;
   logic [ID_W-1:0]  hit_val_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff;
   logic [ID_W-1:0]  next_ff, next_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic             status_ff, status_in;
   logic [ID_W-1:0]  result_ff, result_in;
   wr_type           wr_in;
   logic [IDX_W-1:0] wr_idx_in;
   logic             exec_go;
   logic [ID_W-1:0]  g;
   logic [CNT_W+ECNT_W-1:0] count_ext;

   // search key follows the command
   assign by_host = (cmd_ff == CMD_REGISTER) || (cmd_ff == CMD_GUEST_OF) ||
                    (cmd_ff == CMD_REMOVE);
   assign key     = by_host ? host_ff : guest_ff;
   assign launch  = launch_ff;

   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // command effects, applied in the execute cycle
   always_comb begin
      g         = next_ff;
      next_in   = next_ff;
      count_in  = count_ff;
      status_in = 1'b1;
      result_in = '0;
      wr_in     = '0;
      wr_idx_in = free_idx_ff;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (guest_ff != '0 && host_ff != '0) begin
               if (hit_ff) begin
                  wr_in     = '{en: 1'b1, guest: guest_ff, host: host_ff};
                  wr_idx_in = hit_idx_ff;
                  next_in   = raise_next(next_ff, guest_ff);
                  status_in = 1'b0;
               end else if (free_ff) begin
                  wr_in     = '{en: 1'b1, guest: guest_ff, host: host_ff};
                  wr_idx_in = free_idx_ff;
                  count_in  = count_ff + 1'b1;
                  next_in   = raise_next(next_ff, guest_ff);
                  status_in = 1'b0;
               end
            end
         end
         CMD_REGISTER: begin
            if (host_ff != '0) begin
               if (hit_ff) begin
                  status_in = 1'b0;
                  result_in = hit_val_ff;
               end else begin
                  // counter stays above every stored guest, so no guest match
                  next_in = bump_next(next_ff);
                  if (g != '0 && g != ID_MAX && free_ff) begin
                     wr_in     = '{en: 1'b1, guest: g, host: host_ff};
                     wr_idx_in = free_idx_ff;
                     count_in  = count_ff + 1'b1;
                     status_in = 1'b0;
                     result_in = g;
                  end
               end
            end
         end
         CMD_ALLOC: begin
            next_in = bump_next(next_ff);
            if (g != '0 && g != ID_MAX) begin
               status_in = 1'b0;
               result_in = g;
            end
         end
         CMD_HOST_OF: begin
            result_in = guest_ff;
            if (guest_ff != '0) begin
               if (hit_ff) begin
                  status_in = 1'b0;
                  result_in = hit_val_ff;
               end else if (!mapping_active) begin
                  status_in = 1'b0;
               end
            end
         end
         CMD_GUEST_OF: begin
            result_in = host_ff;
            if (host_ff != '0) begin
               if (hit_ff) begin
                  status_in = 1'b0;
                  result_in = hit_val_ff;
               end else if (!mapping_active) begin
                  status_in = 1'b0;
               end
            end
         end
         CMD_REMOVE: begin
            if (host_ff != '0 && hit_ff) begin
               wr_in     = '{en: 1'b1, guest: '0, host: '0};
               wr_idx_in = hit_idx_ff;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               status_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign wr     = '{en: wr_in.en && exec_go, guest: wr_in.guest, host: wr_in.host};
   assign wr_idx = wr_idx_in;

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         next_ff      <= ID_W'(1);
         count_ff     <= '0;
         cmd_ff       <= CMD_ADD;
      end else begin
         launch_ff <= (state_ff == S_IDLE) && req_valid;
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_cmd);
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_last.vld) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  next_ff  <= next_in;
                  count_ff <= count_in;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         guest_ff <= req_guest_id;
         host_ff  <= req_host_id;
      end
      if (state_ff == S_SCAN && scan_last.vld) begin
         hit_ff      <= scan_last.hit;
         hit_val_ff  <= scan_last.hit_val;
         free_ff     <= scan_last.free_hit;
         hit_idx_ff  <= hit_idx_last;
         free_idx_ff <= free_idx_last;
      end
      if (exec_go) begin
         status_ff <= status_in;
         result_ff <= result_in;
      end
   end

   assign count_ext       = {{ECNT_W{1'b0}}, count_ff};
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_id   = result_ff;
   assign rsp_entry_count = count_ext[ECNT_W-1:0];

endmodule
